### design/slvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scoped local variable stack package
// Operation and status codes, state encoding and transfer payload types.
// ----------------------------------------------------------------------------
package slvs_pkg;

   typedef enum logic [2:0] {
      OP_PUSH  = 3'd0,
      OP_POP   = 3'd1,
      OP_READ  = 3'd2,
      OP_WRITE = 3'd3,
      OP_ENTER = 3'd4,
      OP_LEAVE = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_FULL        = 3'd1,
      ST_EMPTY       = 3'd2,
      ST_BAD_INDEX   = 3'd3,
      ST_SCOPE_FULL  = 3'd4,
      ST_SCOPE_EMPTY = 3'd5,
      ST_BELOW_MARK  = 3'd6
   } status_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_type;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [31:0] value;
      logic [9:0]         index;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [2:0]         status;
      logic [10:0]        stack_depth;
      logic               stack_empty;
      logic [6:0]         scope_depth;
   } rsp_type;

endpackage

### design/slvs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scoped stack RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module slvs_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32,
   parameter int AW    = 10
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/scoped_local_variable_stack_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scoped local variable stack
// Value stack with a stack of scope marks, both held in synchronous RAMs.
//
//   channel  dir  payload   transfer when
//   req_     in   req_type  req_valid && !req_stall
//   rsp_     out  rsp_type  rsp_valid && !rsp_stall
//
// Each operation reads the value or mark RAM in the IDLE state, then updates
// the counts, writes back and loads the result register in the EXEC state.
// Reset clears the counts, the state and the result valid; RAM contents
// are not cleared.
// A held result accepts the next request in the cycle it is taken.
// ----------------------------------------------------------------------------
module scoped_local_variable_stack_top
   import slvs_pkg::*;
#(
   parameter int STACK_DEPTH = 1024,
   parameter int SCOPE_DEPTH = 64,
   parameter int WORD_WIDTH  = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int SA  = $clog2(STACK_DEPTH);
   localparam int CW  = $clog2(STACK_DEPTH + 1);
   localparam int XW  = (CW > 10) ? CW : 10;
   localparam int SAW = (SCOPE_DEPTH > 1) ? $clog2(SCOPE_DEPTH) : 1;
   localparam int SCW = $clog2(SCOPE_DEPTH + 1);

   fsm_type          state_ff, state_in;
   req_type          req_ff;
   logic [CW-1:0]    count_ff, count_in;
   logic [SCW-1:0]   scount_ff, scount_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             accept;
   logic [CW-1:0]    count_dec;
   logic [SCW-1:0]   scount_dec;
   logic [XW-1:0]    req_idx_x, idx_x;

   logic             v_rd_en, v_wr_en, s_rd_en, s_wr_en;
   logic [SA-1:0]    v_rd_addr, v_wr_addr;
   logic [SAW-1:0]   s_rd_addr, s_wr_addr;
   logic [WORD_WIDTH-1:0] v_rd_data, v_wr_data;
   logic [CW-1:0]    s_rd_data;

   logic signed [WORD_WIDTH-1:0] word_in, word_out;
   status_type       status;
   logic signed [31:0] rd_value;

   assign req_stall  = (state_ff == FSM_EXEC) || (rsp_valid_ff && rsp_stall);
   assign accept     = req_valid && !req_stall;
   assign count_dec  = count_ff - CW'(1);
   assign scount_dec = scount_ff - SCW'(1);
   assign req_idx_x  = XW'(req_data.index);
   assign idx_x      = XW'(req_ff.index);

   // issue the RAM read for the accepted request
   always_comb begin
      v_rd_en   = 1'b0;
      s_rd_en   = 1'b0;
      v_rd_addr = req_idx_x[SA-1:0];
      s_rd_addr = SAW'(scount_dec);
      if (accept) begin
         unique case (req_data.operation)
            OP_POP: begin
               v_rd_en   = 1'b1;
               v_rd_addr = count_dec[SA-1:0];
            end
            OP_READ: begin
               v_rd_en = 1'b1;
            end
            OP_LEAVE: begin
               s_rd_en = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   assign word_in  = WORD_WIDTH'(req_ff.value);
   assign word_out = v_rd_data;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scount_in    = scount_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status       = ST_OK;
      rd_value     = '0;
      v_wr_en      = 1'b0;
      v_wr_addr    = idx_x[SA-1:0];
      v_wr_data    = word_in;
      s_wr_en      = 1'b0;
      s_wr_addr    = SAW'(scount_ff);
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            state_in = FSM_IDLE;
            unique case (req_ff.operation)
               OP_PUSH: begin
                  if (count_ff >= CW'(STACK_DEPTH)) begin
                     status = ST_FULL;
                  end else begin
                     v_wr_en   = 1'b1;
                     v_wr_addr = count_ff[SA-1:0];
                     count_in  = count_ff + CW'(1);
                  end
               end
               OP_POP: begin
                  if (count_ff == '0) begin
                     status = ST_EMPTY;
                  end else begin
                     count_in = count_dec;
                     rd_value = 32'(word_out);
                  end
               end
               OP_READ: begin
                  if (idx_x >= XW'(count_ff)) begin
                     status = ST_BAD_INDEX;
                  end else begin
                     rd_value = 32'(word_out);
                  end
               end
               OP_WRITE: begin
                  if (idx_x >= XW'(count_ff)) begin
                     status = ST_BAD_INDEX;
                  end else begin
                     v_wr_en = 1'b1;
                  end
               end
               OP_ENTER: begin
                  if (scount_ff >= SCW'(SCOPE_DEPTH)) begin
                     status = ST_SCOPE_FULL;
                  end else begin
                     s_wr_en   = 1'b1;
                     scount_in = scount_ff + SCW'(1);
                  end
               end
               OP_LEAVE: begin
                  if (scount_ff == '0) begin
                     status = ST_SCOPE_EMPTY;
                  end else begin
                     scount_in = scount_dec;
                     if (count_ff >= s_rd_data) begin
                        count_in = s_rd_data;
                     end else begin
                        status = ST_BELOW_MARK;
                     end
                  end
               end
               default: begin
               end
            endcase
            rsp_in.read_value  = rd_value;
            rsp_in.status      = status;
            rsp_in.stack_depth = 11'(count_in);
            rsp_in.stack_empty = (count_in == '0);
            rsp_in.scope_depth = 7'(scount_in);
            rsp_valid_in       = 1'b1;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         scount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scount_ff    <= scount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the request and the result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   slvs_ram #(
      .DEPTH (STACK_DEPTH),
      .WIDTH (WORD_WIDTH),
      .AW    (SA)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (v_wr_en),
      .wr_addr (v_wr_addr),
      .wr_data (v_wr_data),
      .rd_en   (v_rd_en),
      .rd_addr (v_rd_addr),
      .rd_data (v_rd_data)
   );

   slvs_ram #(
      .DEPTH (SCOPE_DEPTH),
      .WIDTH (CW),
      .AW    (SAW)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (s_wr_en),
      .wr_addr (s_wr_addr),
      .wr_data (count_ff),
      .rd_en   (s_rd_en),
      .rd_addr (s_rd_addr),
      .rd_data (s_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### sim/scoped_local_variable_stack_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scoped local variable stack checker
// Watches both channels of the stack block. Each accepted request is run
// through a local copy of the value stack and the scope mark stack, and the
// expected result is queued. Each accepted result is compared field by field
// with the oldest queued one. Faults are counted and handed to the bench top.
// ----------------------------------------------------------------------------
module scoped_local_variable_stack_checker
   import slvs_pkg::*;
#(
   parameter int STACK_DEPTH = 1024,
   parameter int SCOPE_DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fault_count,
   output int      outstanding,
   output int      stack_level
);

   logic [31:0] word_store [STACK_DEPTH];
   int          scope_mark [SCOPE_DEPTH];
   int          entry_count;
   int          mark_count;
   rsp_type     awaited_rsp [$];

   task automatic report_fault(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      fault_count++;
   endtask

   function automatic rsp_type apply_stack_op(input req_type r);
      rsp_type o;
      int      mark;
      o = '0;
      o.status = ST_OK;
      case (r.operation)
         OP_PUSH: begin
            if (entry_count >= STACK_DEPTH) begin
               o.status = ST_FULL;
            end else begin
               word_store[entry_count] = r.value;
               entry_count++;
            end
         end
         OP_POP: begin
            if (entry_count == 0) begin
               o.status = ST_EMPTY;
            end else begin
               entry_count--;
               o.read_value = word_store[entry_count];
            end
         end
         OP_READ: begin
            if (int'(r.index) >= entry_count) begin
               o.status = ST_BAD_INDEX;
            end else begin
               o.read_value = word_store[r.index];
            end
         end
         OP_WRITE: begin
            if (int'(r.index) >= entry_count) begin
               o.status = ST_BAD_INDEX;
            end else begin
               word_store[r.index] = r.value;
            end
         end
         OP_ENTER: begin
            if (mark_count >= SCOPE_DEPTH) begin
               o.status = ST_SCOPE_FULL;
            end else begin
               scope_mark[mark_count] = entry_count;
               mark_count++;
            end
         end
         OP_LEAVE: begin
            if (mark_count == 0) begin
               o.status = ST_SCOPE_EMPTY;
            end else begin
               mark_count--;
               mark = scope_mark[mark_count];
               if (entry_count >= mark) begin
                  entry_count = mark;
               end else begin
                  o.status = ST_BELOW_MARK;
               end
            end
         end
         default: begin
         end
      endcase
      o.stack_depth = 11'(entry_count);
      o.stack_empty = (entry_count == 0);
      o.scope_depth = 7'(mark_count);
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         awaited_rsp.delete();
         entry_count = 0;
         mark_count  = 0;
         outstanding <= 0;
         stack_level <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               report_fault("result transfer with no result expected");
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_data.read_value !== want.read_value)
                  report_fault($sformatf("read_value got %0d expected %0d",
                                         rsp_data.read_value, want.read_value));
               if (rsp_data.status !== want.status)
                  report_fault($sformatf("status got %0d expected %0d",
                                         rsp_data.status, want.status));
               if (rsp_data.stack_depth !== want.stack_depth)
                  report_fault($sformatf("stack_depth got %0d expected %0d",
                                         rsp_data.stack_depth, want.stack_depth));
               if (rsp_data.stack_empty !== want.stack_empty)
                  report_fault($sformatf("stack_empty got %0b expected %0b",
                                         rsp_data.stack_empty, want.stack_empty));
               if (rsp_data.scope_depth !== want.scope_depth)
                  report_fault($sformatf("scope_depth got %0d expected %0d",
                                         rsp_data.scope_depth, want.scope_depth));
            end
         end
         if (req_valid && !req_stall)
            awaited_rsp.push_back(apply_stack_op(req_data));
         outstanding <= awaited_rsp.size();
         stack_level <= entry_count;
      end
   end

endmodule

### sim/scoped_local_variable_stack_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scoped local variable stack testbench
// Drives push, pop, indexed read and write, scope enter and scope leave
// requests into the stack block: a directed run through the error cases,
// random mixed traffic under four idling patterns, then a fill to full inside
// an open scope, scope overflow and a full unwind. The checker beside the
// block predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module scoped_local_variable_stack_top_tb;
   import slvs_pkg::*;

   localparam int         STACK_DEPTH = 1024;
   localparam int         SCOPE_DEPTH = 64;
   localparam int         CYCLE_LIMIT = 300000;
   localparam logic [2:0] OP_SPARE_A  = 3'd6;
   localparam logic [2:0] OP_SPARE_B  = 3'd7;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int fault_count;
   int outstanding;
   int stack_level;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;

   scoped_local_variable_stack_top #(
      .STACK_DEPTH (STACK_DEPTH),
      .SCOPE_DEPTH (SCOPE_DEPTH),
      .WORD_WIDTH  (32)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   scoped_local_variable_stack_checker #(
      .STACK_DEPTH (STACK_DEPTH),
      .SCOPE_DEPTH (SCOPE_DEPTH)
   ) stack_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .fault_count (fault_count),
      .outstanding (outstanding),
      .stack_level (stack_level)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_op(input logic [2:0] op, input logic [31:0] val,
                          input logic [9:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{operation: op, value: val, index: idx};
      do @(posedge clock); while (req_stall);
   endtask

   task automatic await_quiet();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic set_idling(input int sender, input int receiver);
      send_idle_pct = sender;
      stall_pct <= receiver;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(15))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [9:0] pick_index();
      int roll;
      roll = $urandom_range(99);
      if (stack_level > 0 && roll < 75)
         return 10'($urandom_range(stack_level - 1));
      if (roll < 85 && stack_level < STACK_DEPTH)
         return 10'(stack_level);
      return 10'($urandom_range(STACK_DEPTH - 1));
   endfunction

   task automatic send_mixed();
      logic [2:0] op;
      int         roll;
      roll = $urandom_range(99);
      if (roll < 30) op = OP_PUSH;
      else if (roll < 44) op = OP_POP;
      else if (roll < 58) op = OP_READ;
      else if (roll < 72) op = OP_WRITE;
      else if (roll < 85) op = OP_ENTER;
      else if (roll < 97) op = OP_LEAVE;
      else op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
      send_op(op, pick_value(), pick_index());
   endtask

   task automatic send_filling();
      logic [2:0] op;
      int         roll;
      roll = $urandom_range(99);
      if (roll < 96) op = OP_PUSH;
      else if (roll < 98) op = OP_READ;
      else if (roll < 99) op = OP_WRITE;
      else op = OP_ENTER;
      send_op(op, pick_value(), pick_index());
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // error cases on an empty block, then marks and cuts
      send_op(OP_POP,     32'h0,         10'd0);
      send_op(OP_LEAVE,   32'h0,         10'd0);
      send_op(OP_READ,    32'h0,         10'd0);
      send_op(OP_WRITE,   32'h1234_5678, 10'd0);
      send_op(OP_SPARE_A, 32'hFFFF_FFFF, 10'd1023);
      send_op(OP_SPARE_B, 32'h8000_0000, 10'd512);
      send_op(OP_PUSH,    32'h7FFF_FFFF, 10'd0);
      send_op(OP_PUSH,    32'h8000_0000, 10'd0);
      send_op(OP_PUSH,    32'h0000_0000, 10'd0);
      send_op(OP_PUSH,    32'hFFFF_FFFF, 10'd0);
      send_op(OP_READ,    32'h0,         10'd0);
      send_op(OP_READ,    32'h0,         10'd3);
      send_op(OP_READ,    32'h0,         10'd4);
      send_op(OP_READ,    32'h0,         10'd1023);
      send_op(OP_WRITE,   32'hFFFF_FFFF, 10'd1);
      send_op(OP_WRITE,   32'h5555_AAAA, 10'd1023);
      send_op(OP_ENTER,   32'h0,         10'd0);
      send_op(OP_PUSH,    32'h0000_0005, 10'd0);
      send_op(OP_LEAVE,   32'h0,         10'd0);
      send_op(OP_ENTER,   32'h0,         10'd0);
      send_op(OP_POP,     32'h0,         10'd0);
      send_op(OP_POP,     32'h0,         10'd0);
      send_op(OP_LEAVE,   32'h0,         10'd0);
      send_op(OP_POP,     32'h0,         10'd0);
      send_op(OP_POP,     32'h0,         10'd0);
      await_quiet();

      set_idling(0, 0);
      repeat (25) send_mixed();
      set_idling(58, 0);
      repeat (25) send_mixed();
      await_quiet();
      set_idling(0, 58);
      repeat (25) send_mixed();
      set_idling(35, 35);
      repeat (25) send_mixed();
      await_quiet();

      // open a low scope, fill to full, overflow both stacks, then unwind
      send_op(OP_ENTER, 32'h0, 10'd0);
      while (stack_level < STACK_DEPTH) send_filling();
      repeat (4) send_op(OP_PUSH, pick_value(), 10'd0);
      send_op(OP_READ,  32'h0,        10'd1023);
      send_op(OP_WRITE, pick_value(), 10'd1023);
      send_op(OP_READ,  32'h0,        10'd1023);
      set_idling(0, 58);
      repeat (SCOPE_DEPTH + 6) send_op(OP_ENTER, 32'h0, 10'd0);
      set_idling(58, 0);
      repeat (SCOPE_DEPTH + 2) send_op(OP_LEAVE, 32'h0, pick_index());
      while (stack_level > 0) send_op(OP_POP, 32'h0, 10'd0);
      send_op(OP_POP, 32'h0, 10'd0);

      await_quiet();
      repeat (10) @(posedge clock);
      if (fault_count == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
